// ===== hw/rtl/clt_pkg.sv =====
// Shared types, constants and a helper function of the calculator-language tokenizer.
package clt_pkg;

   localparam int MAX_TOKEN_LEN = 32;
   localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 1);
   localparam int IDX_W         = $clog2(MAX_TOKEN_LEN);
   localparam int Q_DEPTH       = 4;
   localparam int Q_PTR_W       = $clog2(Q_DEPTH);
   localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);

   // token kinds
   localparam logic [3:0] K_LPAREN = 4'd0;
   localparam logic [3:0] K_RPAREN = 4'd1;
   localparam logic [3:0] K_ADD    = 4'd2;
   localparam logic [3:0] K_SUB    = 4'd3;
   localparam logic [3:0] K_MUL    = 4'd4;
   localparam logic [3:0] K_DIV    = 4'd5;
   localparam logic [3:0] K_ASSIGN = 4'd6;
   localparam logic [3:0] K_NUMBER = 4'd7;
   localparam logic [3:0] K_IDENT  = 4'd8;
   localparam logic [3:0] K_READ   = 4'd9;
   localparam logic [3:0] K_WRITE  = 4'd10;
   localparam logic [3:0] K_EOF    = 4'd11;

   // error codes
   localparam logic [2:0] E_NONE     = 3'd0;
   localparam logic [2:0] E_COLON    = 3'd1;
   localparam logic [2:0] E_DOLLAR   = 3'd2;
   localparam logic [2:0] E_TWO_DOTS = 3'd3;
   localparam logic [2:0] E_DOT_END  = 3'd4;
   localparam logic [2:0] E_UNKNOWN  = 3'd5;
   localparam logic [2:0] E_TOO_LONG = 3'd6;

   // characters
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_EQUALS = 8'h3D;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CASE_GAP  = 8'h20;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [3:0] token_kind;
      logic [7:0] token_char;
      logic       last_of_token;
      logic [2:0] error_code;
      logic       number_touches_letter;
   } rsp_type;

   // one queued emit command: a whole token or a single result
   typedef struct packed {
      logic [3:0]       kind;
      logic [7:0]       ch;
      logic [LEN_W-1:0] len;
      logic [2:0]       err;
      logic             warn;
      logic             from_buf;
      logic             bank;
   } cmd_type;

   typedef struct packed {
      logic    valid0;
      logic    valid1;
      cmd_type cmd0;
      cmd_type cmd1;
   } qpush_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } qhead_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } rel_type;

   typedef struct packed {
      logic             en;
      logic             bank;
      logic [IDX_W-1:0] idx;
      logic [7:0]       data;
   } wr_type;

   // lower-case keyword text
   function automatic logic [7:0] kw_char(logic [3:0] kind, logic [2:0] idx);
      logic [7:0] r;
      r = CH_NUL;
      if (kind == K_READ) begin
         unique case (idx)
            3'd0:    r = "r";
            3'd1:    r = "e";
            3'd2:    r = "a";
            3'd3:    r = "d";
            default: r = CH_NUL;
         endcase
      end else if (kind == K_WRITE) begin
         unique case (idx)
            3'd0:    r = "w";
            3'd1:    r = "r";
            3'd2:    r = "i";
            3'd3:    r = "t";
            3'd4:    r = "e";
            default: r = CH_NUL;
         endcase
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/clt_front.sv =====
// Scanner front end: classifies characters, builds tokens and queues emit commands.
module clt_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  clt_pkg::req_type   req_data,
   input  logic [clt_pkg::Q_CNT_W-1:0] q_count,
   output clt_pkg::qpush_type q_push,
   output clt_pkg::wr_type    buf_wr,
   input  clt_pkg::rel_type   rel
);
   import clt_pkg::*;

   localparam logic [3:0] M_IDLE    = 4'd0;
   localparam logic [3:0] M_COLON   = 4'd1;
   localparam logic [3:0] M_DOLLAR  = 4'd2;
   localparam logic [3:0] M_SLASH   = 4'd3;
   localparam logic [3:0] M_COMMENT = 4'd4;
   localparam logic [3:0] M_CSTAR   = 4'd5;
   localparam logic [3:0] M_NUMBER  = 4'd6;
   localparam logic [3:0] M_NUMDOT  = 4'd7;
   localparam logic [3:0] M_IDENT   = 4'd8;

   logic [3:0]       mode_ff, mode_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             dot_ff, dot_in;
   logic             halted_ff, halted_in;
   logic             wb_ff, wb_in;
   logic             rd_ok_ff, rd_ok_in;
   logic             wr_ok_ff, wr_ok_in;
   logic [1:0]       busy_ff, busy_in;

   logic       acc, tokeny, start_bank, do_idle;
   logic       f_v, s_v;
   cmd_type    f_cmd, s_cmd;
   logic [7:0] c, up;
   logic       is_dig, is_alp, is_idc;

   function automatic cmd_type mk_single(logic [3:0] kind, logic [7:0] ch);
      cmd_type r;
      r          = '0;
      r.kind     = kind;
      r.ch       = ch;
      r.len      = LEN_W'(1);
      return r;
   endfunction

   function automatic cmd_type mk_err(logic [2:0] code);
      cmd_type r;
      r     = mk_single(K_LPAREN, CH_NUL);
      r.err = code;
      return r;
   endfunction

   function automatic cmd_type mk_text(logic [3:0] kind, logic [LEN_W-1:0] len);
      cmd_type r;
      r      = mk_single(kind, CH_NUL);
      r.len  = len;
      return r;
   endfunction

   function automatic cmd_type mk_buf(logic [3:0] kind, logic [LEN_W-1:0] len,
                                      logic warn, logic bank);
      cmd_type r;
      r          = mk_text(kind, len);
      r.warn     = warn;
      r.from_buf = 1'b1;
      r.bank     = bank;
      return r;
   endfunction

   assign c      = req_data.ch;
   assign is_dig = (c >= "0") && (c <= "9");
   assign is_alp = ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
   assign is_idc = is_alp || is_dig || (c == CH_UNDER);
   assign up     = ((c >= "a") && (c <= "z")) ? c - CASE_GAP : c;

   // a delimiter that ends a token may start a new one in the other bank
   assign tokeny     = (mode_ff == M_NUMBER) || (mode_ff == M_IDENT);
   assign start_bank = tokeny ? ~wb_ff : wb_ff;
   assign req_ready  = (q_count <= Q_CNT_W'(Q_DEPTH - 2)) && !busy_ff[start_bank];
   assign acc        = req_valid && req_ready;

   always_comb begin
      mode_in   = mode_ff;
      len_in    = len_ff;
      dot_in    = dot_ff;
      halted_in = halted_ff;
      wb_in     = wb_ff;
      rd_ok_in  = rd_ok_ff;
      wr_ok_in  = wr_ok_ff;
      f_v       = 1'b0;
      s_v       = 1'b0;
      f_cmd     = '0;
      s_cmd     = '0;
      buf_wr    = '0;
      do_idle   = 1'b0;

      if (acc && !halted_ff) begin
         if (req_data.end_of_input) begin
            halted_in = 1'b1;
            s_v       = 1'b1;
            s_cmd     = mk_single(K_EOF, CH_DOLLAR);
            unique case (mode_ff)
               M_NUMBER: begin
                  f_v   = 1'b1;
                  f_cmd = mk_buf(K_NUMBER, len_ff, 1'b0, wb_ff);
               end
               M_IDENT: begin
                  f_v = 1'b1;
                  if ((len_ff == LEN_W'(4)) && rd_ok_ff)      f_cmd = mk_text(K_READ, len_ff);
                  else if ((len_ff == LEN_W'(5)) && wr_ok_ff) f_cmd = mk_text(K_WRITE, len_ff);
                  else f_cmd = mk_buf(K_IDENT, len_ff, 1'b0, wb_ff);
               end
               M_SLASH: begin
                  f_v   = 1'b1;
                  f_cmd = mk_single(K_DIV, CH_SLASH);
               end
               M_NUMDOT: s_cmd = mk_err(E_DOT_END);
               M_COLON:  s_cmd = mk_err(E_COLON);
               M_DOLLAR: s_cmd = mk_err(E_DOLLAR);
               default:  ;
            endcase
         end else begin
            unique case (mode_ff)
               M_COLON: begin
                  s_v = 1'b1;
                  if (c == CH_EQUALS) begin
                     s_cmd   = mk_text(K_ASSIGN, LEN_W'(2));
                     mode_in = M_IDLE;
                  end else begin
                     s_cmd     = mk_err(E_COLON);
                     halted_in = 1'b1;
                  end
               end
               M_DOLLAR: begin
                  s_v       = 1'b1;
                  halted_in = 1'b1;
                  s_cmd     = (c == CH_DOLLAR) ? mk_single(K_EOF, CH_DOLLAR)
                                               : mk_err(E_DOLLAR);
               end
               M_SLASH: begin
                  if (c == CH_STAR) begin
                     mode_in = M_COMMENT;
                  end else begin
                     f_v     = 1'b1;
                     f_cmd   = mk_single(K_DIV, CH_SLASH);
                     do_idle = 1'b1;
                  end
               end
               M_COMMENT: begin
                  if (c == CH_LF)        mode_in = M_IDLE;
                  else if (c == CH_STAR) mode_in = M_CSTAR;
               end
               M_CSTAR: begin
                  if ((c == CH_SLASH) || (c == CH_LF)) mode_in = M_IDLE;
                  else if (c != CH_STAR)               mode_in = M_COMMENT;
               end
               M_NUMDOT, M_NUMBER, M_IDENT: begin
                  if ((mode_ff == M_NUMDOT) && !is_dig) begin
                     s_v       = 1'b1;
                     s_cmd     = mk_err(E_DOT_END);
                     halted_in = 1'b1;
                  end else if ((mode_ff == M_NUMBER) && (c == CH_DOT) && dot_ff) begin
                     s_v       = 1'b1;
                     s_cmd     = mk_err(E_TWO_DOTS);
                     halted_in = 1'b1;
                  end else if (((mode_ff != M_IDENT) && (is_dig || (c == CH_DOT))) ||
                               ((mode_ff == M_IDENT) && is_idc)) begin
                     // append to the token being built
                     if (len_ff >= LEN_W'(MAX_TOKEN_LEN)) begin
                        s_v       = 1'b1;
                        s_cmd     = mk_err(E_TOO_LONG);
                        halted_in = 1'b1;
                     end else begin
                        buf_wr.en   = 1'b1;
                        buf_wr.bank = wb_ff;
                        buf_wr.idx  = len_ff[IDX_W-1:0];
                        buf_wr.data = up;
                        len_in      = len_ff + LEN_W'(1);
                        rd_ok_in    = rd_ok_ff && (len_ff < LEN_W'(4)) &&
                                      (up == kw_char(K_READ, len_ff[2:0]) - CASE_GAP);
                        wr_ok_in    = wr_ok_ff && (len_ff < LEN_W'(5)) &&
                                      (up == kw_char(K_WRITE, len_ff[2:0]) - CASE_GAP);
                        if (mode_ff == M_NUMDOT) mode_in = M_NUMBER;
                        else if (c == CH_DOT) begin
                           dot_in  = 1'b1;
                           mode_in = M_NUMDOT;
                        end
                     end
                  end else begin
                     // delimiter: flush, then scan the character afresh
                     f_v     = 1'b1;
                     if (mode_ff == M_NUMBER)
                        f_cmd = mk_buf(K_NUMBER, len_ff, is_alp, wb_ff);
                     else if ((len_ff == LEN_W'(4)) && rd_ok_ff)
                        f_cmd = mk_text(K_READ, len_ff);
                     else if ((len_ff == LEN_W'(5)) && wr_ok_ff)
                        f_cmd = mk_text(K_WRITE, len_ff);
                     else
                        f_cmd = mk_buf(K_IDENT, len_ff, 1'b0, wb_ff);
                     len_in  = '0;
                     wb_in   = ~wb_ff;
                     do_idle = 1'b1;
                  end
               end
               default: do_idle = 1'b1;
            endcase

            if (do_idle) begin
               mode_in = M_IDLE;
               priority if ((c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF)) begin
                  mode_in = M_IDLE;
               end else if (c == CH_LPAREN) begin
                  s_v = 1'b1; s_cmd = mk_single(K_LPAREN, c);
               end else if (c == CH_RPAREN) begin
                  s_v = 1'b1; s_cmd = mk_single(K_RPAREN, c);
               end else if (c == CH_PLUS) begin
                  s_v = 1'b1; s_cmd = mk_single(K_ADD, c);
               end else if (c == CH_MINUS) begin
                  s_v = 1'b1; s_cmd = mk_single(K_SUB, c);
               end else if (c == CH_STAR) begin
                  s_v = 1'b1; s_cmd = mk_single(K_MUL, c);
               end else if (c == CH_COLON) begin
                  mode_in = M_COLON;
               end else if (c == CH_SLASH) begin
                  mode_in = M_SLASH;
               end else if (c == CH_DOLLAR) begin
                  mode_in = M_DOLLAR;
               end else if (is_dig || is_alp) begin
                  buf_wr.en   = 1'b1;
                  buf_wr.bank = wb_in;
                  buf_wr.idx  = '0;
                  buf_wr.data = up;
                  len_in      = LEN_W'(1);
                  dot_in      = 1'b0;
                  mode_in     = is_dig ? M_NUMBER : M_IDENT;
                  rd_ok_in    = (up == kw_char(K_READ, 3'd0) - CASE_GAP);
                  wr_ok_in    = (up == kw_char(K_WRITE, 3'd0) - CASE_GAP);
               end else begin
                  s_v       = 1'b1;
                  s_cmd     = mk_err(E_UNKNOWN);
                  halted_in = 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      q_push.valid0 = f_v || s_v;
      q_push.valid1 = f_v && s_v;
      q_push.cmd0   = f_v ? f_cmd : s_cmd;
      q_push.cmd1   = s_cmd;
      for (int b = 0; b < 2; b++) begin
         busy_in[b] = (busy_ff[b] && !(rel.valid && (rel.bank == 1'(b)))) ||
                      (f_v && f_cmd.from_buf && (f_cmd.bank == 1'(b)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_IDLE;
         len_ff    <= '0;
         dot_ff    <= 1'b0;
         halted_ff <= 1'b0;
         wb_ff     <= 1'b0;
         rd_ok_ff  <= 1'b0;
         wr_ok_ff  <= 1'b0;
         busy_ff   <= '0;
      end else begin
         mode_ff   <= mode_in;
         len_ff    <= len_in;
         dot_ff    <= dot_in;
         halted_ff <= halted_in;
         wb_ff     <= wb_in;
         rd_ok_ff  <= rd_ok_in;
         wr_ok_ff  <= wr_ok_in;
         busy_ff   <= busy_in;
      end
   end

endmodule

// ===== hw/rtl/clt_cmdq.sv =====
// Short command queue between scanner and emitter, up to two pushes per cycle.
module clt_cmdq (
   input  logic               clock,
   input  logic               reset,
   input  clt_pkg::qpush_type q_push,
   input  logic               pop,
   output clt_pkg::qhead_type head,
   output logic [clt_pkg::Q_CNT_W-1:0] count
);
   import clt_pkg::*;

   cmd_type              slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;

   assign head.valid = (count_ff != '0);
   assign head.cmd   = slot_ff[rd_ptr_ff];
   assign count      = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + Q_PTR_W'(q_push.valid0) + Q_PTR_W'(q_push.valid1);
      rd_ptr_in = rd_ptr_ff + Q_PTR_W'(pop);
      count_in  = count_ff + Q_CNT_W'(q_push.valid0) + Q_CNT_W'(q_push.valid1)
                  - Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push.valid0) slot_ff[wr_ptr_ff] <= q_push.cmd0;
      if (q_push.valid1) slot_ff[wr_ptr_ff + Q_PTR_W'(1)] <= q_push.cmd1;
   end

endmodule

// ===== hw/rtl/clt_back.sv =====
// Emitter back end: token buffer banks and the result output register.
module clt_back (
   input  logic               clock,
   input  logic               reset,
   input  clt_pkg::wr_type    buf_wr,
   input  clt_pkg::qhead_type head,
   output logic               pop,
   output clt_pkg::rel_type   rel,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output clt_pkg::rsp_type   rsp_data
);
   import clt_pkg::*;

   logic [7:0]       mem_ff [2][MAX_TOKEN_LEN];
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic [3:0]       kind_ff;
   logic [7:0]       ch_ff, rd_data_ff;
   logic             last_ff, warn_ff, sel_buf_ff;
   logic [2:0]       err_ff;

   logic       adv, take, last;
   logic [7:0] const_ch;

   assign adv  = !valid_ff || rsp_ready;
   assign take = adv && head.valid;
   assign last = ((idx_ff + LEN_W'(1)) == head.cmd.len);
   assign pop  = take && last;

   // buffer bank goes back to the scanner once its last beat is loaded
   assign rel.valid = pop && head.cmd.from_buf;
   assign rel.bank  = head.cmd.bank;

   always_comb begin
      unique case (head.cmd.kind)
         K_ASSIGN:         const_ch = (idx_ff == '0) ? CH_COLON : CH_EQUALS;
         K_READ, K_WRITE:  const_ch = kw_char(head.cmd.kind, idx_ff[2:0]);
         default:          const_ch = head.cmd.ch;
      endcase
      valid_in = adv ? head.valid : valid_ff;
      idx_in   = take ? (last ? '0 : idx_ff + LEN_W'(1)) : idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (buf_wr.en) mem_ff[buf_wr.bank][buf_wr.idx] <= buf_wr.data;
   end

   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff    <= head.cmd.kind;
         ch_ff      <= const_ch;
         last_ff    <= last;
         err_ff     <= head.cmd.err;
         warn_ff    <= head.cmd.warn;
         sel_buf_ff <= head.cmd.from_buf;
         rd_data_ff <= mem_ff[head.cmd.bank][idx_ff[IDX_W-1:0]];
      end
   end

   assign rsp_valid                      = valid_ff;
   assign rsp_data.token_kind            = kind_ff;
   assign rsp_data.token_char            = sel_buf_ff ? rd_data_ff : ch_ff;
   assign rsp_data.last_of_token         = last_ff;
   assign rsp_data.error_code            = err_ff;
   assign rsp_data.number_touches_letter = warn_ff;

endmodule

// ===== hw/rtl/calculator_language_tokenizer.sv =====
// Top level of the calculator-language tokenizer.
// One character (or end-of-input mark) is taken per beat on req_, and tokens leave on rsp_ as
// runs of character beats, the final one flagged last_of_token. The scanner takes a character
// every cycle while it builds a token or skips whitespace and comments, unless req_ready drops;
// each emitted result is one rsp_ beat, so a token of n characters takes n beats on rsp_.
// Number and identifier texts sit in two buffer banks: a token may be built in one bank while
// the other drains, and req_ready drops when the bank a new token needs is still draining or
// the four-entry command queue has fewer than two free slots. After an error or end of file
// the block keeps taking beats and gives nothing until reset. No clearing pass after reset.
module calculator_language_tokenizer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  clt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output clt_pkg::rsp_type rsp_data
);
   import clt_pkg::*;

   qpush_type          q_push;
   qhead_type          head;
   logic [Q_CNT_W-1:0] q_count;
   logic               pop;
   rel_type            rel;
   wr_type             buf_wr;

   clt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_count   (q_count),
      .q_push    (q_push),
      .buf_wr    (buf_wr),
      .rel       (rel)
   );

   clt_cmdq u_cmdq (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .pop    (pop),
      .head   (head),
      .count  (q_count)
   );

   clt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .buf_wr    (buf_wr),
      .head      (head),
      .pop       (pop),
      .rel       (rel),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/clt_checker.sv =====
// Port-level checker for the tokenizer, bound to the top level.
module clt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input clt_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input clt_pkg::rsp_type rsp_data
);
   import clt_pkg::*;

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request beat changed while waiting");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.error_code != E_NONE) |->
         (rsp_data.token_kind == K_LPAREN) && (rsp_data.token_char == CH_NUL) &&
         rsp_data.last_of_token && !rsp_data.number_touches_letter)
      else $error("malformed error beat");

   a_eof_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.token_kind == K_EOF) |->
         rsp_data.last_of_token && (rsp_data.token_char == CH_DOLLAR) &&
         (rsp_data.error_code == E_NONE))
      else $error("malformed end-of-file beat");

   a_quiet_after_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready &&
         ((rsp_data.error_code != E_NONE) || (rsp_data.token_kind == K_EOF)) |=> !rsp_valid)
      else $error("result after error or end of file");

endmodule

bind calculator_language_tokenizer clt_checker u_clt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
